// File: src/crrc_pkg.sv
// Package with the shared types, constants and state codes of the rate controller.
package crrc_pkg;

  localparam int unsigned NumQueues  = 8;
  localparam int unsigned QueueW     = 3;
  localparam int unsigned MaxCatchup = 8;
  localparam int unsigned CntW       = 4;
  localparam logic [16:0] MinDecQ16  = 17'd32768;
  localparam logic [16:0] OneQ16     = 17'd65536;

  localparam int unsigned MulAW = 24;
  localparam int unsigned MulBW = 17;
  localparam int unsigned MulPW = MulAW + MulBW;

  typedef enum logic [2:0] {
    RegLineRate  = 3'd0,
    RegMinRate   = 3'd1,
    RegRateAi    = 3'd2,
    RegRateHai   = 3'd3,
    RegGain      = 3'd4,
    RegByteLimit = 3'd5,
    RegTimerPer  = 3'd6,
    RegFastThr   = 3'd7
  } crrc_reg_e;

  typedef enum logic [1:0] {
    StatUpdated  = 2'd0,
    StatIgnored  = 2'd1,
    StatUntracked = 2'd2
  } crrc_status_e;

  typedef enum logic [3:0] {
    StIdle,
    StDisp,
    StNoticeDec,
    StNoticeMul,
    StNoticeRate,
    StTimerChk,
    StStepMul,
    StStepTgt,
    StStepRate,
    StDone
  } crrc_state_e;

  typedef struct packed {
    logic        op;
    logic [2:0]  queue_index;
    logic [5:0]  feedback;
    logic [13:0] packet_bytes;
    logic [31:0] now;
  } crrc_req_t;

  typedef struct packed {
    logic [2:0]  queue_out;
    logic [23:0] current_rate;
    logic [23:0] target_rate;
    logic [3:0]  increases;
    logic [1:0]  status;
  } crrc_res_t;

endpackage

// File: src/congestion_reaction_rate_control_top.sv
// Top level of the per-queue congestion reaction rate controller.
//
//  channel   | ports                          | handshake
//  ----------+--------------------------------+-------------------------------
//  request   | start, busy, req_i             | taken when start & !busy
//  result    | done_o, res_o                  | one-cycle strobe, no stall
//  config    | cfg_we_i, cfg_idx_i, cfg_data_i | written when cfg_we_i is high
//
// One registered multiplier is shared by the states. A notice runs the dispatch,
// decrement, multiply and rate states; an ignored or untracked request goes to done.
// Transmits step timer check, multiply, target, rate per increase, up to MaxCatchup+1.
// Reset clears all queue state and loads the register defaults.
// The result strobe lasts one cycle and the receiver cannot stall it.
module congestion_reaction_rate_control_top import crrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  crrc_req_t   req_i,
  output logic        done_o,
  output crrc_res_t   res_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic [23:0] line_rate_q, min_rate_q, rate_ai_q, rate_hai_q, byte_limit_q;
  logic [15:0] gain_q;
  logic [31:0] timer_per_q;
  logic [7:0]  fast_thr_q;

  logic [23:0] rate_mem_q  [NumQueues];
  logic [23:0] tgt_mem_q   [NumQueues];
  logic [31:0] bl_mem_q    [NumQueues];
  logic [15:0] bc_mem_q    [NumQueues];
  logic [15:0] tc_mem_q    [NumQueues];
  logic [31:0] dl_mem_q    [NumQueues];

  crrc_state_e state_q, state_d;
  crrc_req_t   req_q;
  logic [23:0] w_rate_q, w_rate_d, w_tgt_q, w_tgt_d;
  logic [31:0] w_bl_q, w_bl_d, w_dl_q, w_dl_d;
  logic [15:0] w_bc_q, w_bc_d, w_tc_q, w_tc_d;
  logic [16:0] dec_q, dec_d;
  logic [CntW-1:0] n_q, n_d, incs_q, incs_d;
  logic        ret_tmr_q, ret_tmr_d;
  logic [1:0]  status_q, status_d;
  logic        done_q;
  crrc_res_t   res_q;

  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] mul_p;

  logic [QueueW-1:0] q_sel;
  logic [23:0] eff_rate;
  logic [15:0] lo_cnt, hi_cnt, thr16, tc_inc, bc_inc;
  logic        lo_pass, hi_pass, tmr_due, can_loop;
  logic [31:0] now_diff;
  logic [32:0] bl_sub;
  logic [40:0] inc_val, tgt_sum;
  logic [27:0] rate_x10;
  logic [24:0] rate_sum;
  logic [23:0] nr_val;

  crrc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_p)
  );

  assign q_sel    = req_q.queue_index;
  assign eff_rate = (w_rate_q == 24'd0) ? line_rate_q : w_rate_q;
  assign thr16    = {8'd0, fast_thr_q};
  assign lo_cnt   = (w_bc_q < w_tc_q) ? w_bc_q : w_tc_q;
  assign hi_cnt   = (w_bc_q < w_tc_q) ? w_tc_q : w_bc_q;
  assign lo_pass  = lo_cnt > thr16;
  assign hi_pass  = hi_cnt > thr16;
  assign now_diff = req_q.now - w_dl_q;
  assign tmr_due  = !now_diff[31];
  assign can_loop = (n_q < CntW'(MaxCatchup)) && tmr_due;
  assign tc_inc   = (w_tc_q == 16'hFFFF) ? w_tc_q : w_tc_q + 16'd1;
  assign bc_inc   = (w_bc_q == 16'hFFFF) ? w_bc_q : w_bc_q + 16'd1;
  assign bl_sub   = {w_bl_q[31], w_bl_q} - {19'd0, req_q.packet_bytes};
  assign inc_val  = lo_pass ? mul_p : (hi_pass ? {17'd0, rate_ai_q} : 41'd0);
  assign tgt_sum  = {17'd0, w_tgt_q} + inc_val;
  assign rate_x10 = {1'b0, eff_rate, 3'd0} + {3'd0, eff_rate, 1'b0};
  assign rate_sum = {1'b0, eff_rate} + {1'b0, w_tgt_q};
  assign nr_val   = mul_p[39:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_rate_q  <= 24'd10000;
      min_rate_q   <= 24'd10;
      rate_ai_q    <= 24'd5;
      rate_hai_q   <= 24'd25;
      gain_q       <= 16'd512;
      byte_limit_q <= 24'd10000;
      timer_per_q  <= 32'd10000;
      fast_thr_q   <= 8'd5;
    end else if (cfg_we_i) begin
      unique case (crrc_reg_e'(cfg_idx_i))
        RegLineRate:  line_rate_q  <= cfg_data_i[23:0];
        RegMinRate:   min_rate_q   <= cfg_data_i[23:0];
        RegRateAi:    rate_ai_q    <= cfg_data_i[23:0];
        RegRateHai:   rate_hai_q   <= cfg_data_i[23:0];
        RegGain:      gain_q       <= cfg_data_i[15:0];
        RegByteLimit: byte_limit_q <= cfg_data_i[23:0];
        RegTimerPer:  timer_per_q  <= cfg_data_i;
        RegFastThr:   fast_thr_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:       if (start) state_d = StDisp;
      StDisp: begin
        if (!req_q.op) begin
          state_d = (req_q.feedback == 6'd0) ? StDone : StNoticeDec;
        end else begin
          state_d = (eff_rate == line_rate_q) ? StDone : StTimerChk;
        end
      end
      StNoticeDec:  state_d = StNoticeMul;
      StNoticeMul:  state_d = StNoticeRate;
      StNoticeRate: state_d = StDone;
      StTimerChk: begin
        if (can_loop || w_bl_q[31]) state_d = StStepMul;
        else                        state_d = StDone;
      end
      StStepMul:    state_d = StStepTgt;
      StStepTgt:    state_d = StStepRate;
      StStepRate:   state_d = ret_tmr_q ? StTimerChk : StDone;
      StDone:       state_d = StIdle;
      default:      state_d = StIdle;
    endcase
  end

  always_comb begin
    w_rate_d  = w_rate_q;
    w_tgt_d   = w_tgt_q;
    w_bl_d    = w_bl_q;
    w_dl_d    = w_dl_q;
    w_bc_d    = w_bc_q;
    w_tc_d    = w_tc_q;
    dec_d     = dec_q;
    n_d       = n_q;
    incs_d    = incs_q;
    ret_tmr_d = ret_tmr_q;
    status_d  = status_q;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      StIdle: begin
        n_d      = '0;
        incs_d   = '0;
        status_d = StatUpdated;
      end
      StDisp: begin
        if (!req_q.op) begin
          if (req_q.feedback == 6'd0) begin
            status_d = StatIgnored;
          end else begin
            if ((eff_rate == line_rate_q) || (w_bc_q != 16'd0)) begin
              w_bl_d  = {8'd0, byte_limit_q};
              w_tgt_d = eff_rate;
            end
            w_bc_d = '0;
            w_tc_d = '0;
            mul_a  = {8'd0, gain_q};
            mul_b  = {11'd0, req_q.feedback};
          end
        end else if (eff_rate == line_rate_q) begin
          status_d = StatUntracked;
        end else begin
          w_bl_d = (bl_sub[32] && !bl_sub[31]) ? 32'h8000_0000 : bl_sub[31:0];
        end
      end
      StNoticeDec: begin
        dec_d = (mul_p < 41'(MinDecQ16)) ? (OneQ16 - mul_p[16:0]) : (OneQ16 - MinDecQ16);
      end
      StNoticeMul: begin
        mul_a = eff_rate;
        mul_b = dec_q;
      end
      StNoticeRate: begin
        w_rate_d = (nr_val < min_rate_q) ? min_rate_q : nr_val;
        w_dl_d   = req_q.now + timer_per_q;
      end
      StTimerChk: begin
        if (can_loop) begin
          w_tc_d    = tc_inc;
          w_dl_d    = w_dl_q + ((tc_inc > thr16) ? {1'b0, timer_per_q[31:1]} : timer_per_q);
          n_d       = n_q + CntW'(1);
          incs_d    = incs_q + CntW'(1);
          ret_tmr_d = 1'b1;
        end else if (w_bl_q[31]) begin
          w_bc_d    = bc_inc;
          w_bl_d    = (bc_inc > thr16) ? {9'd0, byte_limit_q[23:1]} : {8'd0, byte_limit_q};
          incs_d    = incs_q + CntW'(1);
          ret_tmr_d = 1'b0;
        end
      end
      StStepMul: begin
        mul_a = rate_hai_q;
        mul_b = {1'b0, lo_cnt - thr16};
      end
      StStepTgt: begin
        if (((w_bc_q == 16'd1) || (w_tc_q == 16'd1)) && ({4'd0, w_tgt_q} > rate_x10)) begin
          w_tgt_d = {3'd0, w_tgt_q[23:3]};
        end else begin
          w_tgt_d = (tgt_sum > 41'hFF_FFFF) ? 24'hFF_FFFF : tgt_sum[23:0];
        end
      end
      StStepRate: begin
        w_rate_d = (rate_sum[24:1] > line_rate_q) ? line_rate_q : rate_sum[24:1];
      end
      StDone: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == StDone);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) req_q <= req_i;
    w_rate_q  <= (state_q == StIdle) ? rate_mem_q[req_i.queue_index] : w_rate_d;
    w_tgt_q   <= (state_q == StIdle) ? tgt_mem_q[req_i.queue_index] : w_tgt_d;
    w_bl_q    <= (state_q == StIdle) ? bl_mem_q[req_i.queue_index] : w_bl_d;
    w_dl_q    <= (state_q == StIdle) ? dl_mem_q[req_i.queue_index] : w_dl_d;
    w_bc_q    <= (state_q == StIdle) ? bc_mem_q[req_i.queue_index] : w_bc_d;
    w_tc_q    <= (state_q == StIdle) ? tc_mem_q[req_i.queue_index] : w_tc_d;
    dec_q     <= dec_d;
    n_q       <= n_d;
    incs_q    <= incs_d;
    ret_tmr_q <= ret_tmr_d;
    status_q  <= status_d;
    if (state_q == StDone) begin
      res_q.queue_out    <= q_sel;
      res_q.current_rate <= eff_rate;
      res_q.target_rate  <= w_tgt_q;
      res_q.increases    <= incs_q;
      res_q.status       <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumQueues; i++) begin
        rate_mem_q[i] <= '0;
        tgt_mem_q[i]  <= '0;
        bl_mem_q[i]   <= '0;
        bc_mem_q[i]   <= '0;
        tc_mem_q[i]   <= '0;
        dl_mem_q[i]   <= '0;
      end
    end else if (state_q == StDone) begin
      rate_mem_q[q_sel] <= w_rate_q;
      tgt_mem_q[q_sel]  <= w_tgt_q;
      bl_mem_q[q_sel]   <= w_bl_q;
      bc_mem_q[q_sel]   <= w_bc_q;
      tc_mem_q[q_sel]   <= w_tc_q;
      dl_mem_q[q_sel]   <= w_dl_q;
    end
  end

  assign busy   = (state_q != StIdle);
  assign done_o = done_q;
  assign res_o  = res_q;

  // The sequencer never runs more timer steps than the catch-up bound.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CntW'(MaxCatchup))
    else $error("catch-up count exceeded its bound");

  // An accepted request keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not start the sequencer");

  // A result strobe is a single cycle and appears only after the done state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == StDone) && !busy)
    else $error("result strobe without a completed request");

  // Ignored or untracked requests apply no rate increase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status != StatUpdated)) |-> (res_o.increases == '0))
    else $error("increase reported for an ignored request");

endmodule

// File: src/crrc_mul.sv
// Shared registered multiplier used by the gain, rate-decrease and rate-increase steps.
module crrc_mul import crrc_pkg::*; (
  input  logic               clk_i,
  input  logic [MulAW-1:0]   a_i,
  input  logic [MulBW-1:0]   b_i,
  output logic [MulPW-1:0]   prod_o
);

  logic [MulPW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign prod_o = prod_q;

endmodule
